// ----- rtl/core/mseg_pkg.sv -----
// Shared widths, codes, register defaults and the curve table of the envelope generator.
`timescale 1ns / 1ps

package mseg_pkg;

	localparam int TIME_W  = 24;
	localparam int LEVEL_W = 16;
	localparam int SEG_W   = 3;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = TIME_W;
	localparam int PROD_W  = LEVEL_W + TIME_W;

	localparam int CURVE_STEPS    = 256;
	localparam int USE_SQRT_CURVE = 1;
	localparam int CURVE_IDX_W    = $clog2(CURVE_STEPS);
	localparam int CURVE_FULL_W   = $clog2(CURVE_STEPS + 1);
	localparam int CURVE_PROD_W   = LEVEL_W + CURVE_FULL_W;

	localparam int DIV_CNT_W = $clog2(LEVEL_W);

	localparam logic [TIME_W-1:0]  TIME_ONE_RST      = TIME_W'(1000);
	localparam logic [TIME_W-1:0]  TIME_TWO_RST      = TIME_W'(1000);
	localparam logic [TIME_W-1:0]  TIME_THREE_RST    = TIME_W'(1000);
	localparam logic [TIME_W-1:0]  TIME_RELEASE_RST  = TIME_W'(1000);
	localparam logic [LEVEL_W-1:0] LEVEL_ONE_RST     = LEVEL_W'(65535);
	localparam logic [LEVEL_W-1:0] LEVEL_TWO_RST     = LEVEL_W'(49152);
	localparam logic [LEVEL_W-1:0] LEVEL_SUSTAIN_RST = LEVEL_W'(32768);
	localparam logic [LEVEL_W-1:0] LEVEL_FINAL_RST   = LEVEL_W'(0);

	typedef enum logic [SEG_W-1:0] {
		SEG_FIRST,
		SEG_SECOND,
		SEG_THIRD,
		SEG_SUSTAIN,
		SEG_RELEASE,
		SEG_HOLD
	} seg_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_TIME_ONE,
		REG_TIME_TWO,
		REG_TIME_THREE,
		REG_TIME_RELEASE,
		REG_LEVEL_ONE,
		REG_LEVEL_TWO,
		REG_LEVEL_SUSTAIN,
		REG_LEVEL_FINAL
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_MUL,
		ST_DIV,
		ST_LIN,
		ST_OUT
	} state_t;

	typedef logic [LEVEL_W-1:0] curve_tab_t [CURVE_STEPS];

	function automatic logic [LEVEL_W-1:0] isqrt_sat(logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem  = x;
		root = '0;
		b    = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (rem >= root + b) begin
				rem  = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		if (root > 64'(2**LEVEL_W - 1)) begin
			return '1;
		end
		return root[LEVEL_W-1:0];
	endfunction

	function automatic curve_tab_t build_curve();
		curve_tab_t tab;
		for (int i = 0; i < CURVE_STEPS; i++) begin
			tab[i] = isqrt_sat((64'(i) << 32) / CURVE_STEPS);
		end
		return tab;
	endfunction

	localparam curve_tab_t CURVE_TABLE = build_curve();

endpackage

// ----- rtl/core/mseg_if.sv -----
// Valid/ready channel interfaces for items, results and register writes.
`timescale 1ns / 1ps

interface mseg_in_if;
	logic                         valid;
	logic                         ready;
	logic                         key_down;
	logic [mseg_pkg::TIME_W-1:0]  ticks_since_press;
	logic [mseg_pkg::TIME_W-1:0]  ticks_since_release;

	modport source (output valid, key_down, ticks_since_press, ticks_since_release,
		input ready);
	modport sink (input valid, key_down, ticks_since_press, ticks_since_release,
		output ready);
endinterface

interface mseg_out_if;
	logic                         valid;
	logic                         ready;
	logic [mseg_pkg::LEVEL_W-1:0] level;
	logic [mseg_pkg::SEG_W-1:0]   segment;

	modport source (output valid, level, segment, input ready);
	modport sink (input valid, level, segment, output ready);
endinterface

interface mseg_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mseg_pkg::ADDR_W-1:0]  addr;
	logic [mseg_pkg::DATA_W-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/multi_segment_envelope_generator.sv -----
// Four-segment envelope generator: segment select, bit-serial divide, curve map.
`timescale 1ns / 1ps

// Usage:
// item carries one tick (key_down, ticks_since_press, ticks_since_release);
// result returns one beat per item: the envelope level and its segment code.
// cfg writes one register per beat (addr 0..7: four segment times, then the
// four levels); it is always ready. It must be written only while the block
// idles; the block itself does not enforce this. A ramping segment passes
// through accept, segment select (one subtract and compare per pressed
// segment), multiply, divide (one quotient bit per cycle from a restoring
// divider), forming the level and the curve lookup. Sustain and final hold
// skip the multiply and divide.
// One item is in flight at a time; item.ready is high again once its result
// sits in the output register, so the next item is taken while that beat
// waits. A stalled result holds the block before its output cycle.
// Reset restores the register defaults and clears the captured levels and
// the previous key state; the curve table is a constant and needs no fill.
module multi_segment_envelope_generator (
	input  logic           clk,
	input  logic           arst_n,
	mseg_in_if.sink        item,
	mseg_out_if.source     result,
	mseg_cfg_if.sink       cfg
);
	import mseg_pkg::*;

	state_t state_q, state_d;

	logic [TIME_W-1:0]  time_one_q, time_two_q, time_three_q, time_release_q;
	logic [LEVEL_W-1:0] level_one_q, level_two_q, level_sustain_q, level_final_q;

	logic [LEVEL_W-1:0] last_level_q, press_level_q, release_level_q;
	logic               key_was_down_q;

	logic               key_q;
	logic [TIME_W-1:0]  t_q;
	logic [1:0]         phase_q;
	seg_t               seg_q;
	logic [LEVEL_W-1:0] a_q, b_q;
	logic [TIME_W-1:0]  span_q;
	logic               direct_q;
	logic               up_q;
	logic [TIME_W-1:0]  rem_q;
	logic [LEVEL_W-1:0] pq_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEVEL_W-1:0] lin_q;

	logic               out_valid_q;
	logic [LEVEL_W-1:0] out_level_q;
	seg_t               out_seg_q;

	// control outputs of the sequencer
	logic in_take, sel_step, mul_go, div_step, lin_go, out_load;

	// segment select
	logic               sel_hit;
	seg_t               sel_seg;
	logic [LEVEL_W-1:0] sel_a, sel_b;
	logic [TIME_W-1:0]  sel_span;
	logic               sel_direct;
	logic [TIME_W-1:0]  sel_t_next;

	// datapath
	logic [LEVEL_W-1:0] diff;
	logic [PROD_W-1:0]  prod;
	logic [TIME_W:0]    div_shift;
	logic               div_bit;
	logic [TIME_W:0]    div_sub;
	logic [LEVEL_W-1:0] lin_d;
	logic [CURVE_PROD_W-1:0] idx_prod;
	logic [CURVE_FULL_W-1:0] idx_full;
	logic [CURVE_IDX_W-1:0]  idx;
	logic [LEVEL_W-1:0] level_map;

	assign cfg.ready = 1'b1;

	// segment select: one bound per cycle, carrying the elapsed time past it
	always_comb begin
		sel_hit    = 1'b0;
		sel_seg    = SEG_FIRST;
		sel_a      = press_level_q;
		sel_b      = level_one_q;
		sel_span   = time_one_q;
		sel_direct = 1'b0;
		sel_t_next = t_q;
		if (!key_q) begin
			sel_hit = 1'b1;
			sel_a   = release_level_q;
			sel_b   = level_final_q;
			sel_span = time_release_q;
			if (t_q < time_release_q) begin
				sel_seg = SEG_RELEASE;
			end else begin
				sel_seg    = SEG_HOLD;
				sel_direct = 1'b1;
			end
		end else begin
			unique case (phase_q)
				2'd0: begin
					sel_a    = press_level_q;
					sel_b    = level_one_q;
					sel_span = time_one_q;
					if (t_q <= time_one_q) begin
						sel_hit    = 1'b1;
						sel_seg    = SEG_FIRST;
						sel_direct = (time_one_q == '0);
					end else begin
						sel_t_next = t_q - time_one_q;
					end
				end
				2'd1: begin
					sel_a    = level_one_q;
					sel_b    = level_two_q;
					sel_span = time_two_q;
					if (t_q <= time_two_q) begin
						sel_hit = 1'b1;
						sel_seg = SEG_SECOND;
					end else begin
						sel_t_next = t_q - time_two_q;
					end
				end
				default: begin
					sel_a    = level_two_q;
					sel_b    = level_sustain_q;
					sel_span = time_three_q;
					sel_hit  = 1'b1;
					if (t_q <= time_three_q) begin
						sel_seg = SEG_THIRD;
					end else begin
						sel_seg    = SEG_SUSTAIN;
						sel_b      = level_sustain_q;
						sel_direct = 1'b1;
					end
				end
			endcase
		end
	end

	assign diff = (b_q >= a_q) ? (b_q - a_q) : (a_q - b_q);
	assign prod = PROD_W'(diff) * PROD_W'(t_q);

	// restoring divide: shift in the next product bit, subtract span if it fits
	assign div_shift = {rem_q, pq_q[LEVEL_W-1]};
	assign div_bit   = (div_shift >= {1'b0, span_q});
	assign div_sub   = div_bit ? (div_shift - {1'b0, span_q}) : div_shift;

	always_comb begin
		if (direct_q) begin
			lin_d = b_q;
		end else if (up_q) begin
			lin_d = a_q + pq_q;
		end else begin
			lin_d = a_q - pq_q;
		end
	end

	assign idx_prod = CURVE_PROD_W'(lin_q) * CURVE_PROD_W'(CURVE_STEPS);
	assign idx_full = idx_prod[CURVE_PROD_W-1:LEVEL_W];
	assign idx = (idx_full > CURVE_FULL_W'(CURVE_STEPS - 1)) ?
		CURVE_IDX_W'(CURVE_STEPS - 1) : idx_full[CURVE_IDX_W-1:0];
	assign level_map = (USE_SQRT_CURVE != 0) ? CURVE_TABLE[idx] : lin_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				if (sel_hit) begin
					state_d = sel_direct ? ST_LIN : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(LEVEL_W - 1)) begin
					state_d = ST_LIN;
				end
			end
			ST_LIN: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		in_take    = (state_q == ST_IDLE) && item.valid;
		sel_step   = (state_q == ST_SEL);
		mul_go     = (state_q == ST_MUL);
		div_step   = (state_q == ST_DIV);
		lin_go     = (state_q == ST_LIN);
		out_load   = (state_q == ST_OUT) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_one_q      <= TIME_ONE_RST;
			time_two_q      <= TIME_TWO_RST;
			time_three_q    <= TIME_THREE_RST;
			time_release_q  <= TIME_RELEASE_RST;
			level_one_q     <= LEVEL_ONE_RST;
			level_two_q     <= LEVEL_TWO_RST;
			level_sustain_q <= LEVEL_SUSTAIN_RST;
			level_final_q   <= LEVEL_FINAL_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				REG_TIME_ONE:      time_one_q      <= cfg.data;
				REG_TIME_TWO:      time_two_q      <= cfg.data;
				REG_TIME_THREE:    time_three_q    <= cfg.data;
				REG_TIME_RELEASE:  time_release_q  <= cfg.data;
				REG_LEVEL_ONE:     level_one_q     <= cfg.data[LEVEL_W-1:0];
				REG_LEVEL_TWO:     level_two_q     <= cfg.data[LEVEL_W-1:0];
				REG_LEVEL_SUSTAIN: level_sustain_q <= cfg.data[LEVEL_W-1:0];
				REG_LEVEL_FINAL:   level_final_q   <= cfg.data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// envelope state: capture the running level on key edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q    <= '0;
			press_level_q   <= '0;
			release_level_q <= '0;
			key_was_down_q  <= 1'b0;
		end else begin
			if (in_take) begin
				key_was_down_q <= item.key_down;
				if (item.key_down && !key_was_down_q) begin
					press_level_q <= last_level_q;
				end
				if (!item.key_down && key_was_down_q) begin
					release_level_q <= last_level_q;
				end
			end
			if (lin_go) begin
				last_level_q <= lin_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (in_take) begin
				phase_q <= '0;
			end else if (sel_step && !sel_hit) begin
				phase_q <= phase_q + 2'd1;
			end
			if (mul_go) begin
				cnt_q <= '0;
			end else if (div_step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			key_q <= item.key_down;
			t_q   <= item.key_down ? item.ticks_since_press : item.ticks_since_release;
		end else if (sel_step) begin
			t_q <= sel_t_next;
		end
		if (sel_step && sel_hit) begin
			seg_q    <= sel_seg;
			a_q      <= sel_a;
			b_q      <= sel_b;
			span_q   <= sel_span;
			direct_q <= sel_direct;
		end
		if (mul_go) begin
			up_q  <= (b_q >= a_q);
			rem_q <= prod[PROD_W-1:LEVEL_W];
			pq_q  <= prod[LEVEL_W-1:0];
		end else if (div_step) begin
			rem_q <= div_sub[TIME_W-1:0];
			pq_q  <= {pq_q[LEVEL_W-2:0], div_bit};
		end
		if (lin_go) begin
			lin_q <= lin_d;
		end
		if (out_load) begin
			out_level_q <= level_map;
			out_seg_q   <= seg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.level   = out_level_q;
	assign result.segment = out_seg_q;

endmodule
